[hdl/aif_pkg.sv]
// Shared types and constants for the adaptive integrate-and-fire neuron.
// No dependencies; imported by aif_regs, aif_mul and adaptive_integrate_fire_neuron.
package aif_pkg;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_REST   = 3'd0,
        REG_THRESH = 3'd1,
        REG_REFR   = 3'd2,
        REG_TSTEP  = 3'd3,
        REG_MGAIN  = 3'd4,
        REG_AGAIN  = 3'd5,
        REG_ASTEP  = 3'd6,
        REG_AEN    = 3'd7
    } reg_idx_t;

    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;
    localparam int GAIN_WIDTH = 16;
    localparam int TIME_WIDTH = 16;
    localparam int STEP_WIDTH = 15;

    localparam logic [TIME_WIDTH-1:0] REFR_RST  = 16'd6400;
    localparam logic [TIME_WIDTH-1:0] TSTEP_RST = 16'd256;
    localparam logic [GAIN_WIDTH-1:0] MGAIN_RST = 16'd3277;
    localparam logic [GAIN_WIDTH-1:0] AGAIN_RST = 16'd655;
    localparam logic [STEP_WIDTH-1:0] ASTEP_RST = 15'd128;

    localparam longint REST_RST_VAL   = -16640;
    localparam longint THRESH_RST_VAL = -12800;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DECAY = 6'b000010,
        S_ADAPT = 6'b000100,
        S_MEMB  = 6'b001000,
        S_FIRE  = 6'b010000,
        S_PUSH  = 6'b100000
    } seq_state_t;

endpackage

[hdl/aif_regs.sv]
// APB-style configuration register file for the neuron.
// Depends on aif_pkg for the register map and reset constants.
module aif_regs
    import aif_pkg::*;
#(
    parameter int VOLTAGE_WIDTH = 18
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ADDR_WIDTH-1:0]           paddr,
    input  logic [DATA_WIDTH-1:0]           pwdata,
    output logic [DATA_WIDTH-1:0]           prdata,
    output logic                            pready,
    output logic signed [VOLTAGE_WIDTH-1:0] rest,
    output logic signed [VOLTAGE_WIDTH-1:0] thresh,
    output logic [TIME_WIDTH-1:0]           refr_len,
    output logic [TIME_WIDTH-1:0]           tstep,
    output logic [GAIN_WIDTH-1:0]           mgain,
    output logic [GAIN_WIDTH-1:0]           again,
    output logic [STEP_WIDTH-1:0]           astep,
    output logic                            aen
);

    localparam logic signed [VOLTAGE_WIDTH-1:0] REST_RST   = VOLTAGE_WIDTH'(REST_RST_VAL);
    localparam logic signed [VOLTAGE_WIDTH-1:0] THRESH_RST = VOLTAGE_WIDTH'(THRESH_RST_VAL);

    logic signed [VOLTAGE_WIDTH-1:0] rest_reg, thresh_reg;
    logic [TIME_WIDTH-1:0]           refr_reg, tstep_reg;
    logic [GAIN_WIDTH-1:0]           mgain_reg, again_reg;
    logic [STEP_WIDTH-1:0]           astep_reg;
    logic                            aen_reg;
    logic                            wr_en;
    reg_idx_t                        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg   <= REST_RST;
            thresh_reg <= THRESH_RST;
            refr_reg   <= REFR_RST;
            tstep_reg  <= TSTEP_RST;
            mgain_reg  <= MGAIN_RST;
            again_reg  <= AGAIN_RST;
            astep_reg  <= ASTEP_RST;
            aen_reg    <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_REST:   rest_reg   <= pwdata[VOLTAGE_WIDTH-1:0];
                REG_THRESH: thresh_reg <= pwdata[VOLTAGE_WIDTH-1:0];
                REG_REFR:   refr_reg   <= pwdata[TIME_WIDTH-1:0];
                REG_TSTEP:  tstep_reg  <= pwdata[TIME_WIDTH-1:0];
                REG_MGAIN:  mgain_reg  <= pwdata[GAIN_WIDTH-1:0];
                REG_AGAIN:  again_reg  <= pwdata[GAIN_WIDTH-1:0];
                REG_ASTEP:  astep_reg  <= pwdata[STEP_WIDTH-1:0];
                REG_AEN:    aen_reg    <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_REST:   prdata = DATA_WIDTH'(rest_reg);
            REG_THRESH: prdata = DATA_WIDTH'(thresh_reg);
            REG_REFR:   prdata = DATA_WIDTH'(refr_reg);
            REG_TSTEP:  prdata = DATA_WIDTH'(tstep_reg);
            REG_MGAIN:  prdata = DATA_WIDTH'(mgain_reg);
            REG_AGAIN:  prdata = DATA_WIDTH'(again_reg);
            REG_ASTEP:  prdata = DATA_WIDTH'(astep_reg);
            REG_AEN:    prdata = DATA_WIDTH'(aen_reg);
            default:    prdata = '0;
        endcase
    end

    assign rest     = rest_reg;
    assign thresh   = thresh_reg;
    assign refr_len = refr_reg;
    assign tstep    = tstep_reg;
    assign mgain    = mgain_reg;
    assign again    = again_reg;
    assign astep    = astep_reg;
    assign aen      = aen_reg;

endmodule

[hdl/aif_mul.sv]
// Shared Q0.16 gain multiplier: q = floor((x * g + 2^15) / 2^16), registered.
// Depends on aif_pkg for the gain width.
module aif_mul
    import aif_pkg::*;
#(
    parameter int X_WIDTH = 24
)
(
    input  logic                      clk,
    input  logic signed [X_WIDTH-1:0] x,
    input  logic [GAIN_WIDTH-1:0]     g,
    output logic signed [X_WIDTH-1:0] q
);

    localparam int P_WIDTH = X_WIDTH + GAIN_WIDTH + 1;

    logic signed [P_WIDTH-1:0] prod;
    logic signed [P_WIDTH-1:0] rnd;
    logic signed [X_WIDTH-1:0] q_reg;

    assign prod = P_WIDTH'(x) * P_WIDTH'($signed({1'b0, g}));
    // round half up, then arithmetic shift is a floor
    assign rnd  = prod + P_WIDTH'(32768);

    always_ff @(posedge clk)
    begin
        q_reg <= rnd[X_WIDTH+GAIN_WIDTH-1:GAIN_WIDTH];
    end

    assign q = q_reg;

endmodule

[hdl/adaptive_integrate_fire_neuron.sv]
// Adaptive leaky integrate-and-fire neuron, top level: sequencer, state, output beat.
// Depends on aif_pkg, aif_regs (configuration) and aif_mul (shared multiplier).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid / in_stall    | synaptic_current
//  out     | source    | out_valid / out_stall  | spike, voltage, adapt_level
//  cfg     | slave     | psel/penable/pwrite    | paddr, pwdata, prdata
//
// The result beat is loaded into the output register from S_FIRE (from S_ADAPT on
// refractory steps, which skip the membrane update); the next input beat can be taken
// once back in S_IDLE. The multiplier serves the adaptation decay, then the membrane update.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled output holds and the sequencer waits in S_PUSH, taking no new beat.
// Reset is asynchronous and needs no clearing pass.
module adaptive_integrate_fire_neuron
    import aif_pkg::*;
#(
    parameter int VOLTAGE_WIDTH = 18,
    parameter int CURRENT_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ADDR_WIDTH-1:0]           paddr,
    input  logic [DATA_WIDTH-1:0]           pwdata,
    output logic [DATA_WIDTH-1:0]           prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [CURRENT_WIDTH-1:0] synaptic_current,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            spike,
    output logic signed [VOLTAGE_WIDTH-1:0] voltage,
    output logic signed [CURRENT_WIDTH-1:0] adapt_level
);

    localparam int VW = VOLTAGE_WIDTH;
    localparam int CW = CURRENT_WIDTH;
    // difference operand: rest - v + 5*(I - a)
    localparam int DW = ((VW + 1 > CW + 4) ? VW + 1 : CW + 4) + 1;
    // adaptation increment sum
    localparam int AW = ((CW > STEP_WIDTH + 1) ? CW : STEP_WIDTH + 1) + 1;

    localparam longint VMAX = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam longint AMAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint AMIN = -AMAX - 1;
    localparam longint VRST = (REST_RST_VAL < VMIN) ? VMIN : REST_RST_VAL;

    localparam logic signed [DW:0]   V_HI  = (DW + 1)'(VMAX);
    localparam logic signed [DW:0]   V_LO  = (DW + 1)'(VMIN);
    localparam logic signed [CW:0]   A_HI1 = (CW + 1)'(AMAX);
    localparam logic signed [CW:0]   A_LO1 = (CW + 1)'(AMIN);
    localparam logic signed [AW-1:0] A_HI2 = AW'(AMAX);
    localparam logic signed [AW-1:0] A_LO2 = AW'(AMIN);
    localparam logic signed [VW-1:0] V_RST = VW'(VRST);

    logic signed [VW-1:0]    rest, thresh;
    logic [TIME_WIDTH-1:0]   refr_len, tstep;
    logic [GAIN_WIDTH-1:0]   mgain, again, mul_g;
    logic [STEP_WIDTH-1:0]   astep;
    logic                    aen;

    seq_state_t              state_reg, state_next;
    logic signed [CW-1:0]    cur_reg;
    logic signed [VW-1:0]    volt_reg, volt_next;
    logic [TIME_WIDTH-1:0]   refr_reg, refr_next;
    logic signed [CW-1:0]    adapt_reg, adapt_next;
    logic                    spike_reg, spike_next;
    logic signed [DW-1:0]    op_reg, op_next;
    logic signed [DW-1:0]    q;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_spike_reg;
    logic signed [VW-1:0]    out_volt_reg;
    logic signed [CW-1:0]    out_adapt_reg;
    logic                    out_free, out_load, in_take;

    logic signed [CW:0]      dec_sum;
    logic signed [CW-1:0]    a_dec, a_new;
    logic signed [DW-1:0]    ia_diff, diff;
    logic signed [DW:0]      v_sum;
    logic signed [VW-1:0]    v_sat;
    logic signed [AW-1:0]    inc_sum;
    logic signed [CW-1:0]    a_inc;
    logic [TIME_WIDTH-1:0]   dt;

    aif_regs #(
        .VOLTAGE_WIDTH (VW)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .rest     (rest),
        .thresh   (thresh),
        .refr_len (refr_len),
        .tstep    (tstep),
        .mgain    (mgain),
        .again    (again),
        .astep    (astep),
        .aen      (aen)
    );

    assign mul_g = (state_reg == S_DECAY) ? again : mgain;

    aif_mul #(
        .X_WIDTH (DW)
    ) u_mul (
        .clk (clk),
        .x   (op_reg),
        .g   (mul_g),
        .q   (q)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // adaptation decay, q holds a * adaptation_gain here
    assign dec_sum = (CW + 1)'(adapt_reg) - q[CW:0];
    assign a_dec   = (dec_sum > A_HI1) ? CW'(AMAX) :
                     (dec_sum < A_LO1) ? CW'(AMIN) : dec_sum[CW-1:0];
    assign a_new   = aen ? a_dec : '0;

    // membrane drive uses the freshly decayed adaptation value
    assign ia_diff = DW'(cur_reg) - DW'(a_new);
    assign diff    = DW'(rest) - DW'(volt_reg) + (ia_diff <<< 2) + ia_diff;

    assign v_sum = (DW + 1)'(volt_reg) + (DW + 1)'(q);
    assign v_sat = (v_sum > V_HI) ? VW'(VMAX) :
                   (v_sum < V_LO) ? VW'(VMIN) : v_sum[VW-1:0];

    assign inc_sum = AW'(adapt_reg) + AW'($signed({1'b0, astep}));
    assign a_inc   = (inc_sum > A_HI2) ? CW'(AMAX) :
                     (inc_sum < A_LO2) ? CW'(AMIN) : inc_sum[CW-1:0];

    assign dt = (tstep == '0) ? TIME_WIDTH'(1) : tstep;

    always_comb
    begin
        state_next = state_reg;
        volt_next  = volt_reg;
        refr_next  = refr_reg;
        adapt_next = adapt_reg;
        spike_next = spike_reg;
        op_next    = op_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = DW'(adapt_reg);
                    state_next = S_DECAY;
                end
            end
            S_DECAY:
            begin
                state_next = S_ADAPT;
            end
            S_ADAPT:
            begin
                adapt_next = a_new;
                spike_next = 1'b0;
                if (refr_reg != '0)
                begin
                    refr_next  = (refr_reg > dt) ? refr_reg - dt : '0;
                    volt_next  = rest;
                    out_load   = out_free;
                    state_next = out_free ? S_IDLE : S_PUSH;
                end
                else
                begin
                    op_next    = diff;
                    state_next = S_MEMB;
                end
            end
            S_MEMB:
            begin
                state_next = S_FIRE;
            end
            S_FIRE:
            begin
                volt_next = v_sat;
                if (v_sat >= thresh)
                begin
                    spike_next = 1'b1;
                    volt_next  = '0;
                    refr_next  = refr_len;
                    if (aen)
                    begin
                        adapt_next = a_inc;
                    end
                end
                out_load   = out_free;
                state_next = out_free ? S_IDLE : S_PUSH;
            end
            S_PUSH:
            begin
                out_load   = out_free;
                state_next = out_free ? S_IDLE : S_PUSH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            volt_reg      <= V_RST;
            refr_reg      <= '0;
            adapt_reg     <= '0;
            spike_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            volt_reg      <= volt_next;
            refr_reg      <= refr_next;
            adapt_reg     <= adapt_next;
            spike_reg     <= spike_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        if (in_take)
        begin
            cur_reg <= synaptic_current;
        end
        if (out_load)
        begin
            out_spike_reg <= spike_next;
            out_volt_reg  <= volt_next;
            out_adapt_reg <= adapt_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign spike       = out_spike_reg;
    assign voltage     = out_volt_reg;
    assign adapt_level = out_adapt_reg;

`ifndef ASSERT_OFF
    a_take_starts_decay: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == S_DECAY)
        else $error("accepted beat did not start the decay multiply");

    a_plain_clears_adapt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADAPT) && !aen |=> adapt_reg == '0)
        else $error("adaptation not cleared while disabled");

    a_refr_holds_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADAPT) && (refr_reg != '0) |=> volt_reg == $past(rest))
        else $error("refractory step did not hold voltage at rest");

    a_spike_zero_volt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_spike_reg |-> out_volt_reg == '0)
        else $error("spike beat with nonzero voltage");
`endif

endmodule
